@@ sv/arscm_pkg.sv @@
`default_nettype none

package arscm_pkg;

  // Build-time defaults for the top-level parameters
  localparam int unsigned MAX_SIDE_DEF    = 256;
  localparam int unsigned STORE_DEPTH_DEF = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  localparam int unsigned SIZE_W = 9;
  localparam int unsigned META_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned GRAY_W = 8;
  localparam int unsigned ONE_Q16 = 65536;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_AXIS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_AXIS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_META_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_META_HIGH   = 3'd4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] sample_value;
    logic               sample_invalid;
  } in_word_t;

  typedef struct packed {
    logic [7:0] gray_level;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_pixel;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_RANGE,
    ST_SETUP,
    ST_DIV,
    ST_COLOR
  } arscm_state_e;

endpackage

`default_nettype wire

@@ sv/arscm_store.sv @@
`default_nettype none

module arscm_store import arscm_pkg::*; #(
  parameter int unsigned DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned WIDTH = SAMPLE_BITS_DEF + 1,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ sv/arscm_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle; the quotient must fit in 8 bits.
module arscm_div import arscm_pkg::*; #(
  parameter int unsigned NW = 44
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NW-1:0]     num_i,
  input  wire logic [NW-9:0]     den_i,
  output logic                   done_o,
  output logic [GRAY_W-1:0]      quo_o
);

  logic [NW-1:0]     rem_q, rem_d;
  logic [NW-1:0]     dsh_q, dsh_d;
  logic [GRAY_W-1:0] quo_q, quo_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              fits;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    fits   = rem_q >= dsh_q;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = {den_i, 8'b0} >> 1;
      quo_d  = '0;
      cnt_d  = 3'd7;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[GRAY_W-2:0], fits};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

@@ sv/auto_range_slice_colormap_unit.sv @@
`default_nettype none

// Auto-ranging slice colormap. Load a 2-D slice one sample word at a time
// (cmd = 0) into the frame memory while the finite minimum and maximum are
// tracked; then request pixels (cmd = 1) and each request returns one
// contrast-stretched gray level with its blue-white-red color, in row-major
// order of the output image, which with transpose set reads the loaded
// slice column-major. A pixel passes these steps when the stretch needs
// the divider: form the address and read the memory, choose the range, set
// up the stretch, run the gray-level divider (eight quotient bits, one per
// cycle, then a done flag), and apply the colormap. A pixel that clamps to
// 0 or 255 skips the divider. The divider sets the pixel rate: the next
// word is taken in the cycle after the output register loads. Input is
// taken only while no pixel is in flight; the output register lets the next
// word in while a finished pixel waits. The memory is not cleared: read a
// pixel only after its sample was loaded. After the last pixel of a frame,
// the load count, the readout position and the running range restart for
// the next frame.
// Configure only while idle.
module auto_range_slice_colormap_unit import arscm_pkg::*; #(
  parameter int unsigned MAX_SIDE    = MAX_SIDE_DEF,
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_word_t             in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_word_t                 out_word_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [META_W-1:0]    cfg_data_i
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned LW  = (SB > META_W) ? SB : META_W;
  localparam int unsigned EW  = LW + 2;
  localparam int unsigned NW  = EW + 8;
  localparam int unsigned SW  = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW  = $clog2(MAX_SIDE);
  localparam int unsigned AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned IW  = 2 * SW;
  localparam int unsigned XW  = (IW > AW) ? IW : AW;
  localparam int unsigned LCW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned TW  = ((IW > LCW) ? IW : LCW) + 1;
  localparam int unsigned CXW = (SIZE_W > SW) ? SIZE_W + 1 : SW + 1;

  // Configuration registers
  logic [SIZE_W-1:0]        first_size_q, second_size_q;
  logic                     transpose_q;
  logic signed [META_W-1:0] meta_low_q, meta_high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_size_q  <= SIZE_W'(256);
      second_size_q <= SIZE_W'(256);
      transpose_q   <= 1'b0;
      meta_low_q    <= '0;
      meta_high_q   <= META_W'(ONE_Q16);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIRST_AXIS:  first_size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_SECOND_AXIS: second_size_q <= cfg_data_i[SIZE_W-1:0];
        CFG_TRANSPOSE:   transpose_q   <= cfg_data_i[0];
        CFG_META_LOW:    meta_low_q    <= cfg_data_i;
        CFG_META_HIGH:   meta_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp sizes to 1..MAX_SIDE
  logic [SW-1:0] w_side, h_side, img_w, img_h;

  always_comb begin
    if (first_size_q == '0) begin
      w_side = SW'(1);
    end else if (CXW'(first_size_q) > CXW'(MAX_SIDE)) begin
      w_side = SW'(MAX_SIDE);
    end else begin
      w_side = SW'(first_size_q);
    end
    if (second_size_q == '0) begin
      h_side = SW'(1);
    end else if (CXW'(second_size_q) > CXW'(MAX_SIDE)) begin
      h_side = SW'(MAX_SIDE);
    end else begin
      h_side = SW'(second_size_q);
    end
  end

  assign img_w = transpose_q ? h_side : w_side;
  assign img_h = transpose_q ? w_side : h_side;

  // Frame state
  logic [LCW-1:0]         load_count_q;
  logic signed [SB-1:0]   min_q, max_q;
  logic                   seen_q;
  logic [CW-1:0]          col_q, row_q;

  arscm_state_e state_q, state_d;

  logic in_fire, load_fire, read_fire, load_ok, out_load, last_px;
  logic [IW-1:0] frame_area;
  logic [SB+31:0] raw_ext;
  logic [SB-1:0]  raw;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign frame_area = IW'(w_side) * IW'(h_side);
  assign load_ok    = (TW'(load_count_q) < TW'(frame_area)) &&
                      (TW'(load_count_q) < TW'(STORE_DEPTH));
  assign load_fire  = in_fire && (in_word_i.cmd == CMD_LOAD) && load_ok;
  assign read_fire  = in_fire && (in_word_i.cmd == CMD_READ);
  assign raw_ext    = {{SB{1'b0}}, in_word_i.sample_value};
  assign raw        = raw_ext[SB-1:0];

  // Frame memory: invalid flag above the sample bits
  logic            st_rd_en;
  logic [AW-1:0]   st_rd_addr;
  logic [SB:0]     st_rd_data;
  logic [XW-1:0]   pix_idx;
  logic            oob_q;

  arscm_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (SB + 1)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (load_fire),
    .wr_addr_i (load_count_q[AW-1:0]),
    .wr_data_i ({in_word_i.sample_invalid, raw}),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data)
  );

  assign pix_idx = transpose_q ? XW'(col_q) * XW'(w_side) + XW'(row_q)
                               : XW'(row_q) * XW'(w_side) + XW'(col_q);
  assign st_rd_addr = pix_idx[AW-1:0];

  // Divider for the stretch
  logic              div_start, div_done;
  logic [NW-1:0]     div_num;
  logic [GRAY_W-1:0] div_quo;
  logic signed [EW-1:0] lo_q, range_q, v_q, d_val;

  arscm_div #(.NW(NW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (range_q[EW-1:0]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign d_val   = v_q - lo_q;
  assign div_num = {d_val[EW-1:0], 8'b0} - NW'(d_val);

  logic out_valid_q;
  assign out_load = (state_q == ST_COLOR) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    st_rd_en  = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (read_fire) state_d = ST_ADDR;
      end
      ST_ADDR: begin
        st_rd_en = 1'b1;
        state_d  = ST_RANGE;
      end
      ST_RANGE: state_d = ST_SETUP;
      ST_SETUP: begin
        if (d_val <= 0 || d_val >= range_q) begin
          state_d = ST_COLOR;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_COLOR;
      end
      ST_COLOR: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Range selection
  logic signed [EW-1:0] min_e, max_e, ml_e, mh_e, dd, dm, lo_sel, range_sel, samp_e;
  assign min_e  = {{(EW-SB){min_q[SB-1]}}, min_q};
  assign max_e  = {{(EW-SB){max_q[SB-1]}}, max_q};
  assign ml_e   = {{(EW-META_W){meta_low_q[META_W-1]}}, meta_low_q};
  assign mh_e   = {{(EW-META_W){meta_high_q[META_W-1]}}, meta_high_q};
  assign samp_e = {{(EW-SB){st_rd_data[SB-1]}}, st_rd_data[SB-1:0]};
  assign dd     = max_e - min_e;
  assign dm     = mh_e - ml_e;

  always_comb begin
    if (dd <= 0) begin
      lo_sel    = ml_e;
      range_sel = (dm <= 0) ? EW'(ONE_Q16) : dm;
    end else begin
      lo_sel    = min_e;
      range_sel = dd;
    end
  end

  logic [GRAY_W-1:0] gray_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ADDR) begin
      oob_q <= ({1'b0, pix_idx} >= (XW+1)'(STORE_DEPTH));
    end
    if (state_q == ST_RANGE) begin
      lo_q    <= lo_sel;
      range_q <= range_sel;
      if (oob_q) begin
        v_q <= '0;
      end else if (st_rd_data[SB]) begin
        v_q <= lo_sel;
      end else begin
        v_q <= samp_e;
      end
    end
    if (state_q == ST_SETUP) begin
      gray_q <= (d_val <= 0) ? '0 : '1;
    end
    if (state_q == ST_DIV && div_done) begin
      gray_q <= div_quo;
    end
  end

  // Colormap from the gray level
  logic [15:0] lo_prod, hi_prod, hi_chk;
  logic [21:0] hi_scaled;
  logic [7:0]  hi_x, hi_q0, hi_val, red_v, green_v, blue_v;

  assign lo_prod   = {gray_q, 8'b0} - 16'(gray_q);
  assign hi_x      = 8'd255 - gray_q;
  assign hi_prod   = {hi_x, 8'b0} - 16'(hi_x);
  assign hi_scaled = {hi_prod[14:0], 7'b0} + 22'(hi_prod);
  assign hi_q0     = hi_scaled[21:14];
  assign hi_chk    = hi_prod - ({hi_q0, 7'b0} - 16'(hi_q0));
  assign hi_val    = (hi_chk >= 16'd127) ? hi_q0 + 8'd1 : hi_q0;

  always_comb begin
    if (!gray_q[7]) begin
      red_v   = lo_prod[14:7];
      green_v = lo_prod[14:7];
      blue_v  = 8'd255;
    end else begin
      red_v   = 8'd255;
      green_v = hi_val;
      blue_v  = hi_val;
    end
  end

  assign last_px = (SW'(col_q) + SW'(1) == img_w) && (SW'(row_q) + SW'(1) == img_h);

  // Output register
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.gray_level <= gray_q;
      out_q.red_out    <= red_v;
      out_q.green_out  <= green_v;
      out_q.blue_out   <= blue_v;
      out_q.last_pixel <= last_px;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Load tracking and readout position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      min_q        <= '0;
      max_q        <= '0;
      seen_q       <= 1'b0;
      col_q        <= '0;
      row_q        <= '0;
    end else begin
      if (load_fire) begin
        load_count_q <= load_count_q + LCW'(1);
        if (!in_word_i.sample_invalid) begin
          if (!seen_q) begin
            min_q  <= signed'(raw);
            max_q  <= signed'(raw);
            seen_q <= 1'b1;
          end else begin
            if (signed'(raw) < min_q) min_q <= signed'(raw);
            if (signed'(raw) > max_q) max_q <= signed'(raw);
          end
        end
      end
      if (read_fire) begin
        // restart a position that lies beyond the image after a size change
        if (SW'(col_q) >= img_w) col_q <= '0;
        if (SW'(row_q) >= img_h) row_q <= '0;
      end
      if (out_load) begin
        if (last_px) begin
          col_q        <= '0;
          row_q        <= '0;
          load_count_q <= '0;
          seen_q       <= 1'b0;
          min_q        <= '0;
          max_q        <= '0;
        end else if (SW'(col_q) + SW'(1) >= img_w) begin
          col_q <= '0;
          row_q <= row_q + CW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  // Checks
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  a_no_range_before_finite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (min_q == '0 && max_q == '0))
    else $error("running range moved without a finite sample");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_px) |=> (load_count_q == '0 && !seen_q))
    else $error("frame state not cleared after last pixel");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    TW'(load_count_q) <= TW'(STORE_DEPTH))
    else $error("load count beyond memory depth");

endmodule

`default_nettype wire

@@ tb/sv/auto_range_slice_colormap_unit_tb.sv @@
`timescale 1ns / 1ps

module auto_range_slice_colormap_unit_tb import arscm_pkg::*;;

  localparam int unsigned SIDE_MAX    = 256;
  localparam int unsigned DEPTH       = 65536;
  localparam int unsigned DRAIN_CYC   = 40;
  localparam longint      CYCLE_LIMIT = 2000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [META_W-1:0]    cfg_data_i = '0;

  auto_range_slice_colormap_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock: 12 ns period.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow of the block: frame memory, range tracker, readout position, registers.
  logic [32:0]    pix_mem [DEPTH];
  bit             pix_written [DEPTH];
  int unsigned    load_cnt;
  longint         run_min, run_max;
  bit             finite_seen;
  int unsigned    col_pos, row_pos;
  int unsigned    axis_a, axis_b;
  bit             transp;
  longint         meta_lo, meta_hi;

  // Pixels predicted but not yet seen at the output.
  out_word_t      pixel_queue [$];

  // Knobs for the idling phases and the long receiver hold-off.
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    hold_off_cycles = 0;

  int unsigned    mismatch_cnt = 0;
  int unsigned    pixels_checked = 0;
  int unsigned    words_sent = 0;
  int unsigned    frames_done = 0;
  longint         cycle_cnt = 0;

  function automatic int unsigned clip_side(int unsigned s);
    if (s < 1) return 1;
    if (s > SIDE_MAX) return SIDE_MAX;
    return s;
  endfunction

  function automatic int unsigned frame_len();
    int unsigned t;
    t = clip_side(axis_a) * clip_side(axis_b);
    return (t > DEPTH) ? DEPTH : t;
  endfunction

  // Memory index the next readout request will hit, counters wrapped as the block does.
  function automatic int unsigned next_pixel_addr();
    int unsigned w, h, iw, ih, c, r;
    w  = clip_side(axis_a);
    h  = clip_side(axis_b);
    iw = transp ? h : w;
    ih = transp ? w : h;
    c  = (col_pos >= iw) ? 0 : col_pos;
    r  = (row_pos >= ih) ? 0 : row_pos;
    return transp ? c * w + r : r * w + c;
  endfunction

  // Advance the shadow by one accepted word; a pixel request queues its expected result.
  function automatic void model_word(in_word_t wd);
    int unsigned w, h, iw, ih, addr, gray, rr, gg, bb;
    longint lo, hi, span, v, d;
    bit last;
    out_word_t px;
    w = clip_side(axis_a);
    h = clip_side(axis_b);
    if (wd.cmd == CMD_LOAD) begin
      if (load_cnt < frame_len()) begin
        pix_mem[load_cnt] = {wd.sample_invalid, wd.sample_value};
        pix_written[load_cnt] = 1'b1;
        if (!wd.sample_invalid) begin
          v = longint'(wd.sample_value);
          if (!finite_seen) begin
            run_min = v;
            run_max = v;
            finite_seen = 1'b1;
          end else begin
            if (v < run_min) run_min = v;
            if (v > run_max) run_max = v;
          end
        end
        load_cnt++;
      end
      return;
    end
    iw = transp ? h : w;
    ih = transp ? w : h;
    if (col_pos >= iw) col_pos = 0;
    if (row_pos >= ih) row_pos = 0;
    addr = transp ? col_pos * w + row_pos : row_pos * w + col_pos;
    lo = run_min;
    hi = run_max;
    if (hi - lo < 1) begin
      lo = meta_lo;
      hi = meta_hi;
    end
    span = hi - lo;
    if (span < 1) span = ONE_Q16;
    if (pix_mem[addr][32]) v = lo;
    else v = longint'($signed(pix_mem[addr][31:0]));
    d = v - lo;
    if (d <= 0) gray = 0;
    else if (d >= span) gray = 255;
    else gray = int'((d * 255) / span);
    if (gray < 128) begin
      rr = (gray * 255) / 128;
      gg = rr;
      bb = 255;
    end else begin
      rr = 255;
      gg = ((255 - gray) * 255) / 127;
      bb = gg;
    end
    last = (col_pos + 1 == iw) && (row_pos + 1 == ih);
    px.gray_level = gray[7:0];
    px.red_out    = rr[7:0];
    px.green_out  = gg[7:0];
    px.blue_out   = bb[7:0];
    px.last_pixel = last;
    pixel_queue = {pixel_queue, px};
    if (last) begin
      col_pos = 0;
      row_pos = 0;
      load_cnt = 0;
      finite_seen = 1'b0;
      run_min = 0;
      run_max = 0;
      frames_done++;
    end else if (col_pos + 1 >= iw) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  // Offer one word, after a random idle gap, and hold it until it is taken.
  // Valid is left high on return so back-to-back words need no extra edge.
  task automatic send_word(in_word_t wd);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      in_word_i  <= in_word_t'($urandom());
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= wd;
    do @(posedge clk_i); while (!in_ready_o);
    model_word(wd);
    words_sent++;
  endtask

  task automatic load_sample(logic [31:0] val, bit bad);
    in_word_t wd;
    wd.cmd = CMD_LOAD;
    wd.sample_value = val;
    wd.sample_invalid = bad;
    send_word(wd);
  endtask

  // Readout words carry random don't-care sample bits.
  task automatic read_pixel();
    in_word_t wd;
    wd.cmd = CMD_READ;
    wd.sample_value = $urandom();
    wd.sample_invalid = $urandom_range(1);
    send_word(wd);
  endtask

  // Drop valid and wait until the block has drained.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pixel_queue.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // Register write; only called once the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FIRST_AXIS:  axis_a  = val[8:0];
      CFG_SECOND_AXIS: axis_b  = val[8:0];
      CFG_TRANSPOSE:   transp  = val[0];
      CFG_META_LOW:    meta_lo = longint'($signed(val));
      CFG_META_HIGH:   meta_hi = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_frame(int unsigned a, int unsigned b, bit t);
    write_reg(CFG_FIRST_AXIS, a);
    write_reg(CFG_SECOND_AXIS, b);
    write_reg(CFG_TRANSPOSE, t);
  endtask

  task automatic read_frame();
    repeat (frame_len()) read_pixel();
  endtask

  // Samples of varied shape: full range, narrow cluster, constants, extremes.
  function automatic logic [31:0] pick_sample(int unsigned style, logic [31:0] base);
    case (style)
      0: return $urandom();
      1: return base + $urandom_range(65536 * 4);
      2: return base;
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  // Directed: extremes of the samples, invalid samples, all range fallbacks,
  // transpose, ignored loads and readout wrap after a resize.
  task automatic test_directed();
    set_frame(2, 2, 1'b0);
    write_reg(CFG_META_LOW, 32'h0000_0000);
    write_reg(CFG_META_HIGH, 32'h0001_0000);
    load_sample(32'h8000_0000, 1'b0);
    load_sample(32'h7FFF_FFFF, 1'b0);
    load_sample(32'h1234_5678, 1'b1);
    load_sample(32'h0000_0000, 1'b0);
    load_sample(32'hDEAD_BEEF, 1'b0);   // beyond the frame: ignored
    read_frame();
    // Flat data falls back to the metadata range.
    write_reg(CFG_META_LOW, 32'hFFFF_0000);
    write_reg(CFG_META_HIGH, 32'h0002_0000);
    repeat (4) load_sample(32'h0000_8000, 1'b0);
    read_frame();
    // Equal metadata bounds: unit range.
    write_reg(CFG_META_HIGH, 32'hFFFF_0000);
    load_sample(32'hFFFF_8000, 1'b0);
    load_sample(32'hFFFF_0000, 1'b1);
    load_sample(32'hFFFF_8000, 1'b0);
    load_sample(32'h0000_0000, 1'b1);
    read_frame();
    // Inverted metadata and no finite sample at all.
    write_reg(CFG_META_LOW, 32'h7FFF_FFFF);
    write_reg(CFG_META_HIGH, 32'h8000_0000);
    repeat (4) load_sample($urandom(), 1'b1);
    read_frame();
    // Transposed 2x3.
    set_frame(2, 3, 1'b1);
    for (int i = 0; i < 6; i++) load_sample(32'h0001_0000 * i, 1'b0);
    read_frame();
    // Shrink the first axis mid-readout so the column counter wraps.
    set_frame(4, 4, 1'b0);
    for (int i = 0; i < 16; i++) load_sample($urandom(), 1'b0);
    repeat (6) read_pixel();
    write_reg(CFG_FIRST_AXIS, 2);
    read_frame();
    // Unknown register index: ignored.
    write_reg(3'd7, $urandom());
  endtask

  // Whole frames with random content; noise adds stray loads and early reads.
  task automatic test_random_frames(int unsigned n_words);
    int unsigned start, a, b, style;
    logic [31:0] base;
    start = words_sent;
    while (words_sent - start < n_words) begin
      a = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 8);
      b = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 8);
      if (clip_side(a) * clip_side(b) > 64) a = $urandom_range(1, 8);
      set_frame(a, b, $urandom_range(1));
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_META_LOW, $urandom());
        write_reg(CFG_META_HIGH, $urandom());
      end
      style = $urandom_range(3);
      base  = $urandom();
      repeat (frame_len()) begin
        if ($urandom_range(15) == 0 && pix_written[next_pixel_addr()]) read_pixel();
        load_sample(pick_sample(style, base), $urandom_range(9) == 0);
      end
      if ($urandom_range(4) == 0) load_sample($urandom(), $urandom_range(1));
      while (load_cnt != 0) begin
        if ($urandom_range(19) == 0) load_sample($urandom(), $urandom_range(1));
        read_pixel();
      end
    end
  endtask

  // Receiver holds off for a long stretch while pixel requests keep coming.
  task automatic test_backpressure();
    set_frame(4, 3, 1'b0);
    for (int i = 0; i < 12; i++) load_sample($urandom(), i == 5);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    hold_off_cycles = 400;
    read_frame();
  endtask

  // Largest side: first axis 0 clips to 1, second above the limit clips to 256.
  task automatic test_largest_side();
    set_frame(0, 300, 1'b1);
    for (int i = 0; i < 256; i++) load_sample(pick_sample(i % 4, 32'h0003_0000), i % 17 == 0);
    read_frame();
  endtask

  // Output side: check every taken pixel, then pick the next ready.
  always @(posedge clk_i) begin
    out_word_t exp_px;
    if (rst_ni && out_valid_o && out_ready_i) begin
      pixels_checked++;
      if (pixel_queue.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected pixel %p", out_word_o);
      end else begin
        exp_px = pixel_queue.pop_front();
        if (out_word_o !== exp_px) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("pixel %0d: exp %0d %0d/%0d/%0d/%0b got %0d %0d/%0d/%0d/%0b",
                     pixels_checked, exp_px.gray_level, exp_px.red_out, exp_px.green_out,
                     exp_px.blue_out, exp_px.last_pixel, out_word_o.gray_level,
                     out_word_o.red_out, out_word_o.green_out, out_word_o.blue_out,
                     out_word_o.last_pixel);
        end
      end
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("auto_range_slice_colormap_unit verification failed");
      $finish;
    end
  end

  initial begin
    load_cnt = 0; run_min = 0; run_max = 0; finite_seen = 0;
    col_pos = 0; row_pos = 0;
    axis_a = 256; axis_b = 256; transp = 0; meta_lo = 0; meta_hi = 65536;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_frames(40);
    send_idle_pct = 83;
    test_random_frames(30);
    send_idle_pct = 0;
    recv_stall_pct = 83;
    test_random_frames(30);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    test_random_frames(30);
    test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_largest_side();
    settle();

    $display("sent %0d words, checked %0d pixels over %0d frames",
             words_sent, pixels_checked, frames_done);
    $display("covered range fallbacks, invalid samples, transpose, clipping and stalls");
    if (mismatch_cnt == 0 && pixel_queue.size() == 0) begin
      $display("auto_range_slice_colormap_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d pixels missing", mismatch_cnt, pixel_queue.size());
      $display("auto_range_slice_colormap_unit verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/arscm_pkg.sv
sv/arscm_store.sv
sv/arscm_div.sv
sv/auto_range_slice_colormap_unit.sv
tb/sv/auto_range_slice_colormap_unit_tb.sv
